// File: rtl/core/kwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and fixed field widths of the k-way sorted merge core.
// ----------------------------------------------------------------------------
package kwm_pkg;

   localparam int ID_BITS   = 3;
   localparam int DATA_BITS = 32;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_CMP,
      ST_EMIT,
      ST_EMPTY
   } kwm_state_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] merged_value;
      logic                        valid_res;
      logic                        last;
      logic                        overflow;
   } kwm_rsp_type;

endpackage

// File: rtl/core/kwm_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_req_if
// Request channel: one list element or end-of-set marker per request.
// ----------------------------------------------------------------------------
interface kwm_req_if
   import kwm_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic [ID_BITS-1:0]          list_id;
   logic signed [DATA_BITS-1:0] value;
   logic                        has_value;
   logic                        end_of_set;

   modport source (output valid, output list_id, output value, output has_value,
                   output end_of_set, input ready);
   modport sink   (input valid, input list_id, input value, input has_value,
                   input end_of_set, output ready);
endinterface

// File: rtl/core/kwm_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_rsp_if
// Response channel: one merged element per response.
// ----------------------------------------------------------------------------
interface kwm_rsp_if
   import kwm_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic signed [DATA_BITS-1:0] merged_value;
   logic                        valid_res;
   logic                        last;
   logic                        overflow;

   modport source (output valid, output merged_value, output valid_res, output last,
                   output overflow, input ready);
   modport sink   (input valid, input merged_value, input valid_res, input last,
                   input overflow, output ready);
endinterface

// File: rtl/core/kwm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_store
// Element memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kwm_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/kwm_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_out_reg
// Response register: holds one merged element until the sink takes it.
// ----------------------------------------------------------------------------
module kwm_out_reg
   import kwm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  kwm_rsp_type item,
   output logic        free,
   kwm_rsp_if.source   rsp_chan
);

   logic        valid_ff;
   logic        valid_in;
   kwm_rsp_type item_ff;

   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = push || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff <= item;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.merged_value = item_ff.merged_value;
   assign rsp_chan.valid_res    = item_ff.valid_res;
   assign rsp_chan.last         = item_ff.last;
   assign rsp_chan.overflow     = item_ff.overflow;

endmodule

// File: rtl/core/k_way_sorted_merge_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core
// Collects up to LISTS sorted lists and emits all elements merged in order.
// ----------------------------------------------------------------------------
// Requests are taken while loading; each with a value appends its element to
// the named list in the element memory. A request with end_of_set starts the
// merge: every merged element is found by a scan of all list heads through
// the single read port of the element memory, one head per cycle. An empty
// set yields one response with valid_res low. Equal heads go out highest
// list first. Elements beyond PER_LIST per list, or for a list number of
// LISTS or more, are dropped and raise overflow. No requests are taken
// during the merge; the store is empty again after the response marked
// last is produced.
module k_way_sorted_merge_core
   import kwm_pkg::*;
#(
   parameter int LISTS      = 8,
   parameter int PER_LIST   = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   kwm_req_if.sink   req_chan,
   kwm_rsp_if.source rsp_chan
);

   localparam int DEPTH  = LISTS * PER_LIST;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LID_W  = $clog2(LISTS);
   localparam int POS_W  = $clog2(PER_LIST + 1);
   localparam int TOT_W  = $clog2(DEPTH + 1);

   kwm_state_type state_ff, state_in;

   logic [POS_W-1:0]      cnt_ff [LISTS];
   logic [POS_W-1:0]      pos_ff [LISTS];
   logic                  drop_ff;
   logic [TOT_W-1:0]      remain_ff;
   logic [LID_W-1:0]      issue_ff;
   logic                  cand_v_ff;
   logic [LID_W-1:0]      cand_idx_ff;
   logic                  best_v_ff;
   logic [LID_W-1:0]      best_idx_ff;
   logic [VALUE_BITS-1:0] best_val_ff;

   logic [LID_W-1:0]      req_lid;
   logic [LID_W-1:0]      tbl_idx;
   logic [POS_W-1:0]      tbl_cnt;
   logic [POS_W-1:0]      tbl_pos;
   logic                  id_ok;
   logic                  room;
   logic                  accept;
   logic                  store;
   logic                  drop_now;
   logic                  take;
   logic                  is_last;

   logic                  mem_rd_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [VALUE_BITS-1:0] mem_wr_data;
   logic [VALUE_BITS-1:0] mem_rd_data;

   logic                  req_ready;
   logic                  out_free;
   logic                  push;
   logic                  emit;
   logic                  finish;
   kwm_rsp_type           rsp_item;

   assign req_lid  = LID_W'(req_chan.list_id);
   assign tbl_idx  = (state_ff == ST_LOAD) ? req_lid : issue_ff;
   assign tbl_cnt  = cnt_ff[tbl_idx];
   assign tbl_pos  = pos_ff[tbl_idx];
   assign id_ok    = 5'(req_chan.list_id) < 5'(LISTS);
   assign room     = tbl_cnt != POS_W'(PER_LIST);
   assign req_ready = state_ff == ST_LOAD;
   assign accept   = req_chan.valid && req_ready;
   assign store    = accept && req_chan.has_value && id_ok && room;
   assign drop_now = accept && req_chan.has_value && !(id_ok && room);
   assign is_last  = remain_ff == TOT_W'(1);

   assign take = cand_v_ff &&
                 (!best_v_ff || ($signed(mem_rd_data) <= $signed(best_val_ff)));

   assign mem_wr_addr = ADDR_W'(tbl_idx) * ADDR_W'(PER_LIST) + ADDR_W'(tbl_cnt);
   assign mem_rd_addr = ADDR_W'(tbl_idx) * ADDR_W'(PER_LIST) + ADDR_W'(tbl_pos);
   assign mem_wr_data = VALUE_BITS'(req_chan.value);

   assign req_chan.ready = req_ready;

   kwm_store #(
      .DEPTH (DEPTH),
      .WIDTH (VALUE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   kwm_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .item     (rsp_item),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mem_rd_en = 1'b0;
      push      = 1'b0;
      emit      = 1'b0;
      finish    = 1'b0;
      rsp_item  = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_chan.end_of_set) begin
               if (remain_ff == '0 && !store) begin
                  state_in = ST_EMPTY;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            mem_rd_en = 1'b1;
            if (issue_ff == LID_W'(LISTS - 1)) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_item.merged_value = DATA_BITS'($unsigned(best_val_ff));
            rsp_item.valid_res    = 1'b1;
            rsp_item.last         = is_last;
            rsp_item.overflow     = drop_ff;
            if (out_free) begin
               push = 1'b1;
               emit = 1'b1;
               if (is_last) begin
                  finish   = 1'b1;
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_EMPTY: begin
            rsp_item.last     = 1'b1;
            rsp_item.overflow = drop_ff;
            if (out_free) begin
               push     = 1'b1;
               finish   = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LISTS; l++) begin
            cnt_ff[l] <= '0;
            pos_ff[l] <= '0;
         end
         drop_ff   <= 1'b0;
         remain_ff <= '0;
         issue_ff  <= '0;
         cand_v_ff <= 1'b0;
         best_v_ff <= 1'b0;
      end else begin
         if (store) begin
            cnt_ff[req_lid] <= tbl_cnt + POS_W'(1);
            remain_ff       <= remain_ff + TOT_W'(1);
         end
         if (drop_now) begin
            drop_ff <= 1'b1;
         end

         cand_v_ff <= (state_ff == ST_SCAN) && (tbl_pos < tbl_cnt);
         if (state_ff == ST_SCAN) begin
            issue_ff <= issue_ff + LID_W'(1);
         end
         if (take) begin
            best_v_ff <= 1'b1;
         end

         if (emit) begin
            best_v_ff <= 1'b0;
            issue_ff  <= '0;
         end
         if (finish) begin
            for (int l = 0; l < LISTS; l++) begin
               cnt_ff[l] <= '0;
               pos_ff[l] <= '0;
            end
            drop_ff   <= 1'b0;
            remain_ff <= '0;
         end else if (emit) begin
            pos_ff[best_idx_ff] <= pos_ff[best_idx_ff] + POS_W'(1);
            remain_ff           <= remain_ff - TOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_idx_ff <= issue_ff;
      if (take) begin
         best_idx_ff <= cand_idx_ff;
         best_val_ff <= mem_rd_data;
      end
   end

endmodule

// File: test/k_way_sorted_merge_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_core_test
// Self-checking bench for the k-way sorted merge core. Requests load lists of
// signed values, mostly sorted, and close each set with an end-of-set request.
// A scoreboard keeps its own copy of the lists, forms the merged run for every
// closed set and compares each response field by field. Both channels stall
// in random bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_core_test;
   import kwm_pkg::*;

   localparam int LISTS        = 8;
   localparam int PER_LIST     = 8;
   localparam int RANDOM_ITEMS = 120;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam longint VALUE_MAX = 64'sd2147483647;

   localparam int SPREAD   = 0;
   localparam int NARROW   = 1;
   localparam int UNSORTED = 2;

   localparam int ANY_LIST    = -1;
   localparam int ROUND_ROBIN = -2;

   class merge_scoreboard;
      logic signed [DATA_BITS-1:0] held [LISTS][$];
      bit          dropped;
      kwm_rsp_type pending [$];
      int          mismatches;
      int          requests;
      int          sets;
      int          overflow_sets;
      int          checked;

      task report_mismatch(string what);
         $display("ERROR at %0t: response %0d: %s", $time, checked, what);
         mismatches++;
      endtask

      function void note_request(logic [ID_BITS-1:0] list_id,
                                 logic signed [DATA_BITS-1:0] value,
                                 logic has_value, logic end_of_set);
         int total;
         int best;
         int k;
         logic signed [DATA_BITS-1:0] best_head;
         requests++;
         if (has_value) begin
            if (int'(list_id) >= LISTS || held[list_id].size() >= PER_LIST)
               dropped = 1'b1;
            else
               held[list_id].push_back(value);
         end
         if (!end_of_set)
            return;
         sets++;
         if (dropped)
            overflow_sets++;
         total = 0;
         for (int l = 0; l < LISTS; l++)
            total += held[l].size();
         if (total == 0)
            pending.push_back('{merged_value: '0, valid_res: 1'b0, last: 1'b1,
                                overflow: dropped});
         best_head = '0;
         for (k = 0; k < total; k++) begin
            best = -1;
            for (int l = 0; l < LISTS; l++) begin
               if (held[l].size() != 0 && (best < 0 || held[l][0] <= best_head)) begin
                  best = l;
                  best_head = held[l][0];
               end
            end
            pending.push_back('{merged_value: best_head, valid_res: 1'b1,
                                last: (k == total - 1), overflow: dropped});
            void'(held[best].pop_front());
         end
         dropped = 1'b0;
      endfunction

      task check_response(logic signed [DATA_BITS-1:0] merged_value, logic valid_res,
                          logic last, logic overflow);
         kwm_rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("nothing expected, got value %h", merged_value));
            return;
         end
         want = pending.pop_front();
         if (merged_value !== want.merged_value)
            report_mismatch($sformatf("merged_value %h, expected %h",
                                      merged_value, want.merged_value));
         if (valid_res !== want.valid_res)
            report_mismatch($sformatf("valid_res %b, expected %b", valid_res,
                                      want.valid_res));
         if (last !== want.last)
            report_mismatch($sformatf("last %b, expected %b", last, want.last));
         if (overflow !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b", overflow,
                                      want.overflow));
      endtask
   endclass

   logic clock;
   logic reset;
   bit   idle_on;
   int   stall_left;
   int   load_items;
   int   noise_items;
   int   cycle_count;

   merge_scoreboard sb = new;

   kwm_req_if req_if ();
   kwm_rsp_if rsp_if ();

   k_way_sorted_merge_core #(
      .LISTS      (LISTS),
      .PER_LIST   (PER_LIST),
      .VALUE_BITS (DATA_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.list_id, req_if.value, req_if.has_value,
                            req_if.end_of_set);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.merged_value, rsp_if.valid_res, rsp_if.last,
                              rsp_if.overflow);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left = $urandom_range(1, 11) - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped at the cycle limit");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_request(input logic [ID_BITS-1:0] list_id,
                               input logic signed [DATA_BITS-1:0] value,
                               input logic has_value, input logic end_of_set);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.list_id    <= list_id;
      req_if.value      <= value;
      req_if.has_value  <= has_value;
      req_if.end_of_set <= end_of_set;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic load_set(input int n_elems, input int mode, input int focus,
                           input bit eos_carries);
      longint tail [LISTS];
      longint v;
      int     id;
      int     k;
      for (int l = 0; l < LISTS; l++)
         tail[l] = (mode == NARROW) ? longint'($urandom_range(0, 3)) - 3
                                    : longint'($signed($urandom()));
      for (k = 0; k < n_elems; k++) begin
         if ($urandom_range(0, 11) == 0) begin
            send_request(ID_BITS'($urandom()), $urandom(), 1'b0, 1'b0);
            noise_items++;
         end
         if (focus >= 0)
            id = focus;
         else if (focus == ROUND_ROBIN)
            id = k % LISTS;
         else
            id = $urandom_range(0, LISTS - 1);
         unique case (mode)
            SPREAD: begin
               v = tail[id];
               if ($urandom_range(0, 3) != 0)
                  v += longint'($urandom() >> $urandom_range(4, 31));
            end
            NARROW: v = tail[id] + $urandom_range(0, 1);
            default: v = longint'($signed($urandom()));
         endcase
         if (v > VALUE_MAX)
            v = tail[id];
         tail[id] = v;
         load_items++;
         send_request(ID_BITS'(id), v[DATA_BITS-1:0], 1'b1,
                      eos_carries && k == n_elems - 1);
      end
      if (!eos_carries || n_elems == 0) begin
         load_items++;
         send_request(ID_BITS'($urandom()), $urandom(), 1'b0, 1'b1);
      end
   endtask

   initial begin
      int i;
      int set_no;
      int pick;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.list_id    <= '0;
      req_if.value      <= '0;
      req_if.has_value  <= 1'b0;
      req_if.end_of_set <= 1'b0;
      idle_on = 1'b1;
      load_items = 0;
      noise_items = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty set, then a bare request that changes nothing, then another empty set
      send_request(3'd0, '0, 1'b0, 1'b1);
      send_request(3'd5, 32'sh1234_5678, 1'b0, 1'b0);
      send_request(3'd2, '0, 1'b0, 1'b1);

      // value extremes, equal heads across and within lists
      send_request(3'd0, 32'sh8000_0000, 1'b1, 1'b0);
      send_request(3'd7, 32'sh7fff_ffff, 1'b1, 1'b0);
      send_request(3'd3, '0, 1'b1, 1'b0);
      send_request(3'd3, '0, 1'b1, 1'b0);
      send_request(3'd5, '0, 1'b1, 1'b0);
      send_request(3'd1, -32'sd1, 1'b1, 1'b1);

      // overfill one list
      for (i = 0; i <= PER_LIST; i++)
         send_request(3'd2, i * 3 - 5, 1'b1, 1'b0);
      send_request(3'd6, '0, 1'b0, 1'b1);

      // unsorted list
      send_request(3'd4, 32'sd5, 1'b1, 1'b0);
      send_request(3'd4, 32'sd1, 1'b1, 1'b0);
      send_request(3'd6, 32'sd3, 1'b1, 1'b0);
      send_request(3'd4, -32'sd7, 1'b1, 1'b1);

      load_items = 0;
      set_no = 0;
      while (load_items < RANDOM_ITEMS) begin
         if (load_items > RANDOM_ITEMS * 3 / 4)
            idle_on = 1'b0;
         else
            idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (set_no == 4)
            load_set(LISTS * PER_LIST + 2, SPREAD, ROUND_ROBIN, 1'b0);
         else if ($urandom_range(0, 7) == 0)
            load_set(PER_LIST + $urandom_range(1, 3), (pick < 5) ? SPREAD : NARROW,
                     $urandom_range(0, LISTS - 1), 1'($urandom_range(0, 1)));
         else
            load_set($urandom_range(0, 10),
                     (pick < 5) ? SPREAD : (pick < 8) ? NARROW : UNSORTED,
                     ANY_LIST, 1'($urandom_range(0, 1)));
         set_no++;
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4 * (LISTS + 2)) @(posedge clock);

      $display("Loaded %0d requests (%0d bare fillers) over %0d sets, %0d with overflow",
               sb.requests, noise_items, sb.sets, sb.overflow_sets);
      $display("Compared %0d merged responses, %0d field errors", sb.checked,
               sb.mismatches);
      if (sb.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
